/* hw/rtl/tsc_pkg.sv */
package tsc_pkg;

  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned MAX_LANES  = 8;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned FIFO_DEPTH = 4;

  typedef logic [ELEM_W-1:0] elem_t;

  typedef struct packed {
    elem_t [MAX_LANES-1:0] elem;
    logic [COUNT_W-1:0]    count;
    logic                  last;
    logic [TOTAL_W-1:0]    total;
  } tsc_result_t;

  typedef struct packed {
    logic full;
    logic flush;
  } tsc_push_t;

endpackage

/* hw/rtl/tsc_lane.sv */
module tsc_lane #(
  parameter int unsigned ELEM_BITS = 32
) (
  input  tsc_pkg::elem_t elem_raw,
  input  tsc_pkg::elem_t threshold,
  output logic           keep,
  output tsc_pkg::elem_t elem_ext
);
  import tsc_pkg::*;

  localparam int unsigned SHIFT = ELEM_W - ELEM_BITS;

  logic signed [ELEM_W-1:0] shifted;

  assign shifted  = elem_raw << SHIFT;
  assign elem_ext = shifted >>> SHIFT;
  assign keep     = $signed(elem_ext) >= $signed(threshold);

endmodule

/* hw/rtl/tsc_merge.sv */
module tsc_merge #(
  parameter int unsigned LANES = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         in_last,
  input  logic [LANES-1:0]             keep,
  input  tsc_pkg::elem_t               elem [LANES],
  output tsc_pkg::tsc_push_t           push,
  output tsc_pkg::tsc_result_t         res_full,
  output tsc_pkg::tsc_result_t         res_last,
  output logic [$clog2(LANES)-1:0]     fill_lvl,
  output logic [tsc_pkg::TOTAL_W-1:0]  total
);
  import tsc_pkg::*;

  localparam int unsigned FILL_W = $clog2(LANES);
  localparam int unsigned POS_W  = $clog2(2 * LANES);
  localparam int unsigned KEPT_W = $clog2(LANES + 1);

  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  elem_t              partial_r [LANES];
  elem_t              partial_nxt [LANES];

  logic [POS_W-1:0]   pos [LANES];
  logic [KEPT_W-1:0]  kept;
  logic [POS_W-1:0]   n_tot;
  logic [POS_W-1:0]   n_rem;
  logic               full;
  elem_t              slot_v [2*LANES];
  elem_t              rem [LANES];
  logic [TOTAL_W:0]   sum;

  always_comb begin
    kept = '0;
    for (int w = 0; w < LANES; w++) begin
      pos[w] = POS_W'(fill_r) + POS_W'(kept);
      if (keep[w]) begin
        kept = kept + 1'b1;
      end
    end
    n_tot = POS_W'(fill_r) + POS_W'(kept);
    full  = n_tot >= POS_W'(LANES);
    n_rem = full ? (n_tot - POS_W'(LANES)) : n_tot;
  end

  always_comb begin
    for (int s = 0; s < 2 * LANES; s++) begin
      slot_v[s] = '0;
    end
    for (int s = 0; s < LANES; s++) begin
      if (FILL_W'(s) < fill_r) begin
        slot_v[s] = partial_r[s];
      end
    end
    for (int w = 0; w < LANES; w++) begin
      for (int s = 0; s < 2 * LANES; s++) begin
        if (keep[w] && (pos[w] == POS_W'(s))) begin
          slot_v[s] = slot_v[s] | elem[w];
        end
      end
    end
    for (int j = 0; j < LANES; j++) begin
      rem[j] = full ? slot_v[j + LANES] : slot_v[j];
    end
  end

  assign sum       = {1'b0, total_r} + (TOTAL_W + 1)'(kept);
  assign total_nxt = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];

  always_comb begin
    res_full       = '0;
    res_last       = '0;
    for (int j = 0; j < LANES; j++) begin
      res_full.elem[j] = slot_v[j];
      res_last.elem[j] = rem[j];
    end
    res_full.count = COUNT_W'(LANES);
    res_full.last  = 1'b0;
    res_full.total = total_nxt;
    res_last.count = COUNT_W'(n_rem);
    res_last.last  = 1'b1;
    res_last.total = total_nxt;
  end

  assign push.full  = step && full;
  assign push.flush = step && in_last;

  always_comb begin
    fill_nxt = fill_r;
    for (int j = 0; j < LANES; j++) begin
      partial_nxt[j] = partial_r[j];
    end
    if (step) begin
      fill_nxt = in_last ? '0 : FILL_W'(n_rem);
      for (int j = 0; j < LANES; j++) begin
        partial_nxt[j] = rem[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      total_r <= '0;
    end else if (step) begin
      fill_r  <= fill_nxt;
      total_r <= in_last ? '0 : total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < LANES; j++) begin
      partial_r[j] <= partial_nxt[j];
    end
  end

  assign fill_lvl = fill_r;
  assign total    = total_r;

endmodule

/* hw/rtl/tsc_res_fifo.sv */
module tsc_res_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tsc_pkg::tsc_push_t   push,
  input  tsc_pkg::tsc_result_t res_full,
  input  tsc_pkg::tsc_result_t res_last,
  input  logic                 pop,
  output tsc_pkg::tsc_result_t head,
  output logic                 not_empty,
  output logic                 room2
);
  import tsc_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  tsc_result_t       mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]        n_push;
  tsc_result_t       first;

  assign n_push    = 2'(push.full) + 2'(push.flush);
  assign first     = push.full ? res_full : res_last;
  assign wptr_nxt  = wptr_r + PTR_W'(n_push);
  assign rptr_nxt  = pop ? PTR_W'(rptr_r + 1'b1) : rptr_r;
  assign count_nxt = count_r + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wptr_r] <= first;
    end
    if (push.full && push.flush) begin
      mem_r[PTR_W'(wptr_r + 1'b1)] <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  assign head      = mem_r[rptr_r];
  assign not_empty = count_r != '0;
  assign room2     = count_r <= CNT_W'(FIFO_DEPTH - 2);

endmodule

/* hw/rtl/threshold_stream_compaction_core.sv */
// Threshold stream compaction. Each item is a vector of LANES elements (the low ELEM_BITS
// bits of each lane, two's complement); elements at or above the threshold are packed in
// lane order into LANES-wide result vectors, and a full vector is sent as soon as it forms.
// An item with in_last set also sends the final partial vector with out_last high, after
// any full vector that item completes, and then the stream state starts over. Every result
// carries the saturating count of kept elements. The block takes one item per clock while
// in_ready is high: the lane compare, the compaction and the state update all happen in the
// cycle of acceptance, and each result is registered into a four-entry result queue, where
// it waits. in_ready is low while fewer than two queue entries are free, so an item that
// gives two results, or a stalled consumer, holds the input only for as long as the queue drains.
module threshold_stream_compaction_core #(
  parameter int unsigned LANES     = 8,
  parameter int unsigned ELEM_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic signed [tsc_pkg::ELEM_W-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [tsc_pkg::ELEM_W-1:0]    in_elem_0,
  input  logic signed [tsc_pkg::ELEM_W-1:0]    in_elem_1,
  input  logic signed [tsc_pkg::ELEM_W-1:0]    in_elem_2,
  input  logic signed [tsc_pkg::ELEM_W-1:0]    in_elem_3,
  input  logic signed [tsc_pkg::ELEM_W-1:0]    in_elem_4,
  input  logic signed [tsc_pkg::ELEM_W-1:0]    in_elem_5,
  input  logic signed [tsc_pkg::ELEM_W-1:0]    in_elem_6,
  input  logic signed [tsc_pkg::ELEM_W-1:0]    in_elem_7,
  input  logic                                 in_last,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tsc_pkg::ELEM_W-1:0]    out_elem_0,
  output logic signed [tsc_pkg::ELEM_W-1:0]    out_elem_1,
  output logic signed [tsc_pkg::ELEM_W-1:0]    out_elem_2,
  output logic signed [tsc_pkg::ELEM_W-1:0]    out_elem_3,
  output logic signed [tsc_pkg::ELEM_W-1:0]    out_elem_4,
  output logic signed [tsc_pkg::ELEM_W-1:0]    out_elem_5,
  output logic signed [tsc_pkg::ELEM_W-1:0]    out_elem_6,
  output logic signed [tsc_pkg::ELEM_W-1:0]    out_elem_7,
  output logic [tsc_pkg::COUNT_W-1:0]          out_count,
  output logic                                 out_last,
  output logic [tsc_pkg::TOTAL_W-1:0]          out_total_kept
);
  import tsc_pkg::*;

  localparam int unsigned FILL_W = $clog2(LANES);

  elem_t              threshold_r;
  elem_t              in_vec [MAX_LANES];
  elem_t              lane_elem [LANES];
  logic [LANES-1:0]   lane_keep;
  logic               step;
  logic               pop;
  tsc_push_t          push;
  tsc_result_t        res_full;
  tsc_result_t        res_last;
  tsc_result_t        head;
  logic [FILL_W-1:0]  fill_lvl;
  logic [TOTAL_W-1:0] total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else if (cfg_we) begin
      threshold_r <= cfg_data;
    end
  end

  assign in_vec[0] = in_elem_0;
  assign in_vec[1] = in_elem_1;
  assign in_vec[2] = in_elem_2;
  assign in_vec[3] = in_elem_3;
  assign in_vec[4] = in_elem_4;
  assign in_vec[5] = in_elem_5;
  assign in_vec[6] = in_elem_6;
  assign in_vec[7] = in_elem_7;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tsc_lane #(
      .ELEM_BITS(ELEM_BITS)
    ) u_lane (
      .elem_raw (in_vec[g]),
      .threshold(threshold_r),
      .keep     (lane_keep[g]),
      .elem_ext (lane_elem[g])
    );
  end

  assign step = in_valid && in_ready;
  assign pop  = out_valid && out_ready;

  tsc_merge #(
    .LANES(LANES)
  ) u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_last (in_last),
    .keep    (lane_keep),
    .elem    (lane_elem),
    .push    (push),
    .res_full(res_full),
    .res_last(res_last),
    .fill_lvl(fill_lvl),
    .total   (total)
  );

  tsc_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .res_full (res_full),
    .res_last (res_last),
    .pop      (pop),
    .head     (head),
    .not_empty(out_valid),
    .room2    (in_ready)
  );

  assign out_elem_0     = head.elem[0];
  assign out_elem_1     = head.elem[1];
  assign out_elem_2     = head.elem[2];
  assign out_elem_3     = head.elem[3];
  assign out_elem_4     = head.elem[4];
  assign out_elem_5     = head.elem[5];
  assign out_elem_6     = head.elem[6];
  assign out_elem_7     = head.elem[7];
  assign out_count      = head.count;
  assign out_last       = head.last;
  assign out_total_kept = head.total;

  a_fill_below_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    FILL_W'(fill_lvl) <= FILL_W'(LANES - 1))
    else $error("Fill level reached the vector width.");

  a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_last) |=> (fill_lvl == '0 && total == '0))
    else $error("Stream state not cleared after the last item.");

  a_partial_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_count != COUNT_W'(LANES)) |-> out_last)
    else $error("Partial vector sent without the last flag.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count <= COUNT_W'(LANES)))
    else $error("Result count exceeds the vector width.");

endmodule

/* sim/threshold_stream_compaction_core_tb.sv */
`timescale 1ns / 1ps

module threshold_stream_compaction_core_tb;
  import tsc_pkg::*;

  localparam int LANE_CNT = 8;
  localparam int NUM_ROWS = 14;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_ITEMS = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam elem_t E_MAX = 32'h7fff_ffff;
  localparam elem_t E_MIN = 32'h8000_0000;
  localparam elem_t E_NEG1 = 32'hffff_ffff;

  typedef elem_t [0:MAX_LANES-1] lane_vec_t;

  typedef struct packed {
    lane_vec_t          lanes;
    logic               last;
    logic               typed;
    elem_t              fill;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic signed [ELEM_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  elem_t in_elem_0, in_elem_1, in_elem_2, in_elem_3;
  elem_t in_elem_4, in_elem_5, in_elem_6, in_elem_7;
  logic in_last;
  logic out_valid;
  logic out_ready = 1'b0;
  elem_t out_elem_0, out_elem_1, out_elem_2, out_elem_3;
  elem_t out_elem_4, out_elem_5, out_elem_6, out_elem_7;
  logic [COUNT_W-1:0] out_count;
  logic out_last;
  logic [TOTAL_W-1:0] out_total_kept;

  logic signed [ELEM_W-1:0] cut_level = '0;
  int stream_fill = 0;
  elem_t stream_slots [MAX_LANES];
  logic [TOTAL_W-1:0] stream_kept = '0;

  tsc_result_t pending_vectors [$];
  stim_row_t directed_rows [NUM_ROWS];
  logic row_typed = 1'b0;
  tsc_result_t typed_res;
  int idle_pct = 0;
  int stall_pct = 0;
  int stalled_cycles = 0;
  int fail_count = 0;

  threshold_stream_compaction_core #(
    .LANES(LANE_CNT),
    .ELEM_BITS(ELEM_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_elem_0(in_elem_0),
    .in_elem_1(in_elem_1),
    .in_elem_2(in_elem_2),
    .in_elem_3(in_elem_3),
    .in_elem_4(in_elem_4),
    .in_elem_5(in_elem_5),
    .in_elem_6(in_elem_6),
    .in_elem_7(in_elem_7),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_elem_0(out_elem_0),
    .out_elem_1(out_elem_1),
    .out_elem_2(out_elem_2),
    .out_elem_3(out_elem_3),
    .out_elem_4(out_elem_4),
    .out_elem_5(out_elem_5),
    .out_elem_6(out_elem_6),
    .out_elem_7(out_elem_7),
    .out_count(out_count),
    .out_last(out_last),
    .out_total_kept(out_total_kept)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tsc_result_t pack_slots(input elem_t staged [2*MAX_LANES], input int count,
                                             input logic last_flag);
    tsc_result_t r;
    r = '0;
    for (int j = 0; j < MAX_LANES; j++) begin
      r.elem[j] = (j < count) ? staged[j] : '0;
    end
    r.count = COUNT_W'(count);
    r.last = last_flag;
    r.total = stream_kept;
    return r;
  endfunction

  function automatic int compact_item(input lane_vec_t lanes, input logic last_flag,
                                      output tsc_result_t [1:0] made);
    elem_t staged [2*MAX_LANES];
    int fill;
    int kept;
    int produced;
    logic [TOTAL_W:0] sum;
    fill = (stream_fill >= LANE_CNT) ? 0 : stream_fill;
    kept = 0;
    produced = 0;
    made = '0;
    for (int w = 0; w < 2*MAX_LANES; w++) begin
      staged[w] = (w < fill) ? stream_slots[w] : '0;
    end
    for (int w = 0; w < LANE_CNT; w++) begin
      if ($signed(lanes[w]) >= cut_level) begin
        staged[fill] = lanes[w];
        fill++;
        kept++;
      end
    end
    sum = {1'b0, stream_kept} + (TOTAL_W+1)'(kept);
    stream_kept = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    if (fill >= LANE_CNT) begin
      made[produced] = pack_slots(staged, LANE_CNT, 1'b0);
      produced++;
      fill -= LANE_CNT;
      for (int w = 0; w < MAX_LANES; w++) begin
        staged[w] = (w < fill) ? staged[w+LANE_CNT] : '0;
      end
    end
    if (last_flag) begin
      made[produced] = pack_slots(staged, fill, 1'b1);
      produced++;
      stream_fill = 0;
      stream_kept = '0;
      for (int w = 0; w < MAX_LANES; w++) begin
        stream_slots[w] = '0;
      end
    end else begin
      stream_fill = fill;
      for (int w = 0; w < MAX_LANES; w++) begin
        stream_slots[w] = (w < fill) ? staged[w] : '0;
      end
    end
    return produced;
  endfunction

  function automatic elem_t pick_lane();
    case ($urandom_range(0, 9))
      0: return E_MIN;
      1: return E_MAX;
      2: return cut_level;
      3: return cut_level - 1;
      4: return cut_level + 1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input lane_vec_t lanes, input logic last_flag);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_elem_0 <= lanes[0];
    in_elem_1 <= lanes[1];
    in_elem_2 <= lanes[2];
    in_elem_3 <= lanes[3];
    in_elem_4 <= lanes[4];
    in_elem_5 <= lanes[5];
    in_elem_6 <= lanes[6];
    in_elem_7 <= lanes[7];
    in_last <= last_flag;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_vectors.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_threshold(input logic signed [ELEM_W-1:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= value;
    cut_level = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : watch_ports
    tsc_result_t seen;
    tsc_result_t want;
    tsc_result_t [1:0] made;
    lane_vec_t lanes;
    int produced;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        lanes = '{in_elem_0, in_elem_1, in_elem_2, in_elem_3,
                  in_elem_4, in_elem_5, in_elem_6, in_elem_7};
        produced = compact_item(lanes, in_last, made);
        if (row_typed) begin
          pending_vectors.push_back(typed_res);
        end else begin
          for (int k = 0; k < produced; k++) begin
            pending_vectors.push_back(made[k]);
          end
        end
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        seen.elem[0] = out_elem_0;
        seen.elem[1] = out_elem_1;
        seen.elem[2] = out_elem_2;
        seen.elem[3] = out_elem_3;
        seen.elem[4] = out_elem_4;
        seen.elem[5] = out_elem_5;
        seen.elem[6] = out_elem_6;
        seen.elem[7] = out_elem_7;
        seen.count = out_count;
        seen.last = out_last;
        seen.total = out_total_kept;
        if (pending_vectors.size() == 0) begin
          $error("unexpected result: out_count %0d out_last %0d", seen.count, seen.last);
          fail_count++;
        end else begin
          want = pending_vectors.pop_front();
          for (int j = 0; j < MAX_LANES; j++) begin
            if (seen.elem[j] !== want.elem[j]) begin
              $error("out_elem_%0d expected %h actual %h", j, want.elem[j], seen.elem[j]);
              fail_count++;
            end
          end
          if (seen.count !== want.count) begin
            $error("out_count expected %0d actual %0d", want.count, seen.count);
            fail_count++;
          end
          if (seen.last !== want.last) begin
            $error("out_last expected %0d actual %0d", want.last, seen.last);
            fail_count++;
          end
          if (seen.total !== want.total) begin
            $error("out_total_kept expected %0d actual %0d", want.total, seen.total);
            fail_count++;
          end
        end
      end
    end
    stalled_cycles = moved ? 0 : stalled_cycles + 1;
  end

  initial begin
    wait (stalled_cycles >= WATCHDOG_LIMIT);
    $display("threshold_stream_compaction_core regression: fail");
    $finish;
  end

  initial begin
    lane_vec_t lanes;
    logic signed [ELEM_W-1:0] phase_cut;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_elem_0 <= '0;
    in_elem_1 <= '0;
    in_elem_2 <= '0;
    in_elem_3 <= '0;
    in_elem_4 <= '0;
    in_elem_5 <= '0;
    in_elem_6 <= '0;
    in_elem_7 <= '0;
    in_last <= 1'b0;
    typed_res = '0;
    for (int w = 0; w < MAX_LANES; w++) begin
      stream_slots[w] = '0;
    end

    // Rows run at the reset threshold of zero; typed rows carry their result in the row.
    directed_rows = '{
      '{'{E_NEG1, E_NEG1, E_NEG1, E_NEG1, E_NEG1, E_NEG1, E_NEG1, E_NEG1},
        1'b1, 1'b1, 32'd0, 4'd0, 32'd0},
      '{'{E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX},
        1'b0, 1'b1, E_MAX, 4'd8, 32'd8},
      '{'{E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN},
        1'b1, 1'b1, 32'd0, 4'd0, 32'd8},
      '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
        1'b0, 1'b1, 32'd0, 4'd8, 32'd8},
      '{'{32'd1, E_NEG1, 32'd2, -32'sd2, 32'd3, -32'sd3, 32'd4, -32'sd4},
        1'b0, 1'b0, 32'd0, 4'd0, 32'd0},
      '{'{32'd5, 32'd6, 32'd7, 32'd8, -32'sd5, -32'sd6, -32'sd7, -32'sd8},
        1'b0, 1'b0, 32'd0, 4'd0, 32'd0},
      '{'{32'd1, 32'd1, 32'd1, E_NEG1, E_NEG1, E_NEG1, E_NEG1, E_NEG1},
        1'b0, 1'b0, 32'd0, 4'd0, 32'd0},
      '{'{32'd9, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9, 32'd9},
        1'b1, 1'b0, 32'd0, 4'd0, 32'd0},
      '{'{E_MIN, E_MAX, 32'd0, E_NEG1, 32'd1, E_MIN + 1, E_MAX - 1, 32'h5555_5555},
        1'b1, 1'b0, 32'd0, 4'd0, 32'd0},
      '{'{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
          32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555},
        1'b0, 1'b0, 32'd0, 4'd0, 32'd0},
      '{'{E_NEG1, E_NEG1, E_NEG1, E_NEG1, E_NEG1, E_NEG1, E_NEG1, E_NEG1},
        1'b0, 1'b0, 32'd0, 4'd0, 32'd0},
      '{'{32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, E_NEG1},
        1'b0, 1'b0, 32'd0, 4'd0, 32'd0},
      '{'{E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX},
        1'b1, 1'b0, 32'd0, 4'd0, 32'd0},
      '{'{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0},
        1'b1, 1'b0, 32'd0, 4'd0, 32'd0}
    };

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row_typed = directed_rows[i].typed;
      if (row_typed) begin
        typed_res = '0;
        for (int j = 0; j < directed_rows[i].count; j++) begin
          typed_res.elem[j] = directed_rows[i].fill;
        end
        typed_res.count = directed_rows[i].count;
        typed_res.last = directed_rows[i].last;
        typed_res.total = directed_rows[i].total;
      end
      send_item(directed_rows[i].lanes, directed_rows[i].last);
    end
    row_typed = 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: phase_cut = E_MIN;
        1: phase_cut = E_MAX;
        2: phase_cut = E_NEG1;
        3: phase_cut = $urandom();
        4: phase_cut = '0;
        default: phase_cut = $urandom_range(0, 200) - 100;
      endcase
      set_threshold(phase_cut);
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 76;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 76;
        end
        default: begin
          idle_pct = 32;
          stall_pct = 32;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        for (int w = 0; w < MAX_LANES; w++) begin
          lanes[w] = pick_lane();
        end
        send_item(lanes, $urandom_range(0, 9) == 0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("threshold_stream_compaction_core regression: pass");
    end else begin
      $display("threshold_stream_compaction_core regression: fail");
    end
    $finish;
  end

endmodule
